>>> rtl/core/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Types and constants shared by the windowed mean / deviation core.
// ----------------------------------------------------------------------------
`default_nettype none

package wms_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned SumW      = 24;
  localparam int unsigned SquareW   = 40;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned Q168W     = 24;
  localparam int unsigned InvW      = 29;
  localparam int unsigned VarW      = 57;
  localparam int unsigned DivCntW   = 6;

  localparam logic [CfgW-1:0]  InverseSizeReset = 32'd89478485;
  localparam logic [Q168W-1:0] Q168Max          = 24'd16776960;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [Q168W-1:0] mean;
    logic [Q168W-1:0] deviation;
    logic [InvW-1:0]  inverse_deviation;
    logic             flat;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_PROD,
    ST_SCALE,
    ST_SQUARE,
    ST_DIFF,
    ST_CHECK,
    ST_DIV,
    ST_SQINIT,
    ST_SQRT,
    ST_DEVMUL,
    ST_DEVFIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accum;
    logic prod;
    logic scale;
    logic square;
    logic diff;
    logic div_init;
    logic div_step;
    logic sq_init;
    logic sq_step;
    logic dev_mul;
    logic dev_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sq_done;
    logic flat;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/wms_ctrl.sv
// ----------------------------------------------------------------------------
// wms_ctrl
// Sequencer: accumulates items, then steps the datapath through the finish.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_ctrl import wms_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_last_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accum = 1'b1;
          if (in_last_i) state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.flat) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = ST_SQINIT;
      end
      ST_SQINIT: begin
        cmd_o.sq_init = 1'b1;
        state_d       = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sq_step = 1'b1;
        if (status_i.sq_done) state_d = ST_DEVMUL;
      end
      ST_DEVMUL: begin
        cmd_o.dev_mul = 1'b1;
        state_d       = ST_DEVFIN;
      end
      ST_DEVFIN: begin
        cmd_o.dev_fin = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/wms_dp.sv
// ----------------------------------------------------------------------------
// wms_dp
// Datapath: sums, scaling multipliers, radix-2 divider, bitwise square root.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_dp import wms_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  input  wire in_item_t         in_item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_item_o
);

  logic [CfgW-1:0]    inv_size_q;
  logic [SumW-1:0]    sum_q;
  logic [SquareW-1:0] sq_q;
  logic [55:0]        pmean_q, phi_q, plo_q;
  logic [Q168W-1:0]   mean_q;
  logic [VarW-1:0]    msq_q;
  logic [47:0]        m2_q;
  logic [VarW-1:0]    var_q;
  logic               flat_q;
  logic [VarW-1:0]    rem_q, quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic [VarW-1:0]    x_q, root_q, bit_q;
  logic [57:0]        pa_q;
  logic [56:0]        pb_q;
  logic [Q168W-1:0]   dev_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [SumW:0]      sum_ext;
  logic [SquareW:0]   sq_ext;
  logic [32:0]        mean_r;
  logic [40:0]        lo_r;
  logic [VarW:0]      shifted, root_t;
  logic               div_ge, sq_ge;
  logic [58:0]        dev_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_size_q <= InverseSizeReset;
    end else if (cfg_we_i) begin
      inv_size_q <= cfg_wdata_i;
    end
  end

  assign sum_ext = {1'b0, sum_q} + {{(SumW+1-SampleW){1'b0}}, in_item_i.sample};
  assign sq_ext  = {1'b0, sq_q}
                 + {9'd0, 32'(in_item_i.sample) * 32'(in_item_i.sample)};

  // saturate both sums, clear them once the products are taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.accum) begin
      sum_q <= sum_ext[SumW] ? {SumW{1'b1}} : sum_ext[SumW-1:0];
      sq_q  <= sq_ext[SquareW] ? {SquareW{1'b1}} : sq_ext[SquareW-1:0];
    end else if (cmd_i.prod) begin
      sum_q <= '0;
      sq_q  <= '0;
    end
  end

  assign mean_r  = 33'((57'(pmean_q) + 57'(1 << 23)) >> 24);
  assign lo_r    = 41'((57'(plo_q) + 57'(16'h8000)) >> 16);
  assign shifted = {rem_q, (cnt_q == DivCntW'(VarW-1))};
  assign div_ge  = shifted >= {1'b0, var_q};
  assign root_t  = {1'b0, root_q} + {1'b0, bit_q};
  assign sq_ge   = {1'b0, x_q} >= root_t;
  assign dev_sum = {1'b0, pa_q} + 59'((58'(pb_q) + 58'(1 << 27)) >> 28);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      pmean_q <= 56'(sum_q) * 56'(inv_size_q);
      phi_q   <= 56'(sq_q) * 56'(inv_size_q[31:16]);
      plo_q   <= 56'(sq_q) * 56'(inv_size_q[15:0]);
    end
    if (cmd_i.scale) begin
      mean_q <= (mean_r > 33'(Q168Max)) ? Q168Max : mean_r[Q168W-1:0];
      msq_q  <= VarW'(phi_q) + VarW'(lo_r);
    end
    if (cmd_i.square) begin
      m2_q <= 48'(mean_q) * 48'(mean_q);
    end
    if (cmd_i.diff) begin
      flat_q <= msq_q <= VarW'(m2_q);
      var_q  <= msq_q - VarW'(m2_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= DivCntW'(VarW-1);
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? VarW'(shifted - {1'b0, var_q}) : shifted[VarW-1:0];
      quo_q <= {quo_q[VarW-2:0], div_ge};
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.sq_init) begin
      x_q    <= quo_q;
      root_q <= '0;
      bit_q  <= VarW'(1) << (VarW-1);
    end else if (cmd_i.sq_step) begin
      if (sq_ge) begin
        x_q    <= x_q - root_t[VarW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.dev_mul) begin
      pa_q <= 58'(var_q[VarW-1:28]) * 58'(root_q[InvW-1:0]);
      pb_q <= 57'(var_q[27:0]) * 57'(root_q[InvW-1:0]);
    end
    if (cmd_i.dev_fin) begin
      dev_q <= (dev_sum > 59'(Q168Max)) ? Q168Max : dev_sum[Q168W-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.mean              <= mean_q;
      out_q.deviation         <= flat_q ? '0 : dev_q;
      out_q.inverse_deviation <= flat_q ? '0 : root_q[InvW-1:0];
      out_q.flat              <= flat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.div_done = (cnt_q == '0);
  assign status_o.sq_done  = bit_q[0];
  assign status_o.flat     = flat_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

`default_nettype wire

>>> rtl/core/window_mean_stddev_core.sv
// ----------------------------------------------------------------------------
// window_mean_stddev_core
// Windowed mean and standard deviation of 16-bit samples with inverse.
// ----------------------------------------------------------------------------
//  channel | signals                       | accepted when
//  in      | in_valid_i/in_ready_o/item    | in_valid_i & in_ready_o
//  out     | out_valid_o/out_ready_i/item  | out_valid_o & out_ready_i
//  cfg     | cfg_we_i/cfg_wdata_i          | cfg_we_i
//
//  A sample without last leaves input ready. The last sample starts the
//  finish, which holds input off; a window that is not flat also
//  runs the 57-step divider and the 29-step square root that share the
//  sequencer. The final finish cycle holds while an earlier result still
//  waits; otherwise the result waits in an output register while the next
//  window accumulates.
//  Reset clears both sums and loads the default reciprocal window size.
// ----------------------------------------------------------------------------
`default_nettype none

module window_mean_stddev_core import wms_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire in_item_t        in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output out_item_t            out_item_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  wms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wms_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/wms_check.sv
// ----------------------------------------------------------------------------
// wms_check
// Port-level checks for the windowed mean / deviation core.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_check import wms_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item dropped or changed while stalled");

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.flat |->
      out_item_o.deviation == '0 && out_item_o.inverse_deviation == '0)
    else $error("flat window with nonzero deviation");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.mean <= Q168Max && out_item_o.deviation <= Q168Max)
    else $error("result above Q16.8 limit");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a finish sequence");

endmodule

bind window_mean_stddev_core wms_check u_wms_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed mean / deviation core: directed rows
// and random windows are driven with random gaps on both channels, and every
// result is checked field by field against a local fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
  import wms_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned NumRandom  = 1250;

  typedef struct {
    in_item_t  item;
    logic      known;
    out_item_t result;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  in_item_t  in_item_i = '0;
  logic      out_ready_i = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  out_item_t stats_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  logic [63:0] inv_size_m;
  logic [63:0] sum_m;
  logic [63:0] sq_m;

  row_t rows[$];

  window_mean_stddev_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("window_mean_stddev_core test failed");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Accumulate one sample; return 1 with the window stats on last.
  function automatic bit window_stats(in_item_t it, output out_item_t res);
    logic [63:0] mean, msq, m2, vari, inv, dev;
    res = '0;
    sum_m = sum_m + it.sample;
    if (sum_m > 64'hFF_FFFF) sum_m = 64'hFF_FFFF;
    sq_m = sq_m + 64'(it.sample) * 64'(it.sample);
    if (sq_m > 64'hFF_FFFF_FFFF) sq_m = 64'hFF_FFFF_FFFF;
    if (!it.last) return 1'b0;
    mean = (sum_m * inv_size_m + (64'd1 << 23)) >> 24;
    if (mean > 64'(Q168Max)) mean = 64'(Q168Max);
    msq = sq_m * (inv_size_m >> 16) + ((sq_m * (inv_size_m & 64'hFFFF) + 64'h8000) >> 16);
    m2 = mean * mean;
    res.mean = mean[23:0];
    if (msq < m2 + 1) begin
      res.flat = 1'b1;
    end else begin
      vari = msq - m2;
      inv = int_sqrt((64'd1 << 56) / vari);
      dev = (vari >> 28) * inv + (((vari & ((64'd1 << 28) - 1)) * inv + (64'd1 << 27)) >> 28);
      if (dev > 64'(Q168Max)) dev = 64'(Q168Max);
      res.deviation = dev[23:0];
      res.inverse_deviation = inv[28:0];
    end
    sum_m = 0;
    sq_m = 0;
    return 1'b1;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic check_item(string tag, out_item_t got, out_item_t want);
    if (got.mean !== want.mean)
      report({tag, " mean"}, 64'(got.mean), 64'(want.mean));
    if (got.deviation !== want.deviation)
      report({tag, " deviation"}, 64'(got.deviation), 64'(want.deviation));
    if (got.inverse_deviation !== want.inverse_deviation)
      report({tag, " inverse"}, 64'(got.inverse_deviation), 64'(want.inverse_deviation));
    if (got.flat !== want.flat)
      report({tag, " flat"}, 64'(got.flat), 64'(want.flat));
  endtask

  // Output side: random stalls, compare each item with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stats_q.size() == 0) begin
        report("unexpected item", 64'd0, 64'd0);
      end else begin
        out_item_t exp_r;
        exp_r = stats_q.pop_front();
        check_item("result", out_item_o, exp_r);
      end
    end
  end

  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 150) : $urandom_range(1, 3);
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
  endfunction

  // Drive at the falling edge; hold valid across items sent back to back.
  task automatic send(in_item_t it, bit known, out_item_t want);
    out_item_t res;
    int g;
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (window_stats(it, res)) begin
      if (known) check_item("predictor row", res, want);
      stats_q.push_back(res);
    end
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Write the register only once all results are out and the finish is over.
  task automatic set_inv_size(logic [CfgW-1:0] v);
    idle_input();
    while (stats_q.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    inv_size_m = 64'(v);
  endtask

  function automatic row_t mk(logic [15:0] s, logic l, logic k = 1'b0,
                              out_item_t r = '0);
    row_t x;
    x.item.sample = s;
    x.item.last = l;
    x.known = k;
    x.result = r;
    return x;
  endfunction

  task automatic random_window(int len, bit full_range);
    in_item_t it;
    logic [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      if (full_range || $urandom_range(0, 3) == 0) it.sample = 16'($urandom);
      else it.sample = base + 16'($urandom_range(0, 3));
      it.last = (i == len - 1);
      send(it, 1'b0, '0);
    end
  endtask

  initial begin
    out_item_t zero_flat;
    row_t r;
    int n;
    inv_size_m = 64'(InverseSizeReset);
    sum_m = 0;
    sq_m = 0;
    zero_flat = '0;
    zero_flat.flat = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows: zero window, single samples, extremes, mixed windows.
    rows.push_back(mk(16'd0, 1'b1, 1'b1, zero_flat));
    rows.push_back(mk(16'd0, 1'b0));
    rows.push_back(mk(16'd0, 1'b1, 1'b1, zero_flat));
    rows.push_back(mk(16'hFFFF, 1'b1));
    rows.push_back(mk(16'hFFFF, 1'b0));
    rows.push_back(mk(16'd0, 1'b1));
    rows.push_back(mk(16'd1, 1'b0));
    rows.push_back(mk(16'd2, 1'b0));
    rows.push_back(mk(16'd3, 1'b1));
    rows.push_back(mk(16'h5555, 1'b0));
    rows.push_back(mk(16'hAAAA, 1'b1));
    rows.push_back(mk(16'd7, 1'b0));
    rows.push_back(mk(16'd7, 1'b1));
    foreach (rows[i]) send(rows[i].item, rows[i].known, rows[i].result);

    // Register extremes; zero gives a flat zero-mean window.
    set_inv_size(32'd0);
    r = mk(16'd1000, 1'b0);
    send(r.item, 1'b0, '0);
    r = mk(16'd9, 1'b1);
    send(r.item, 1'b1, zero_flat);
    set_inv_size(32'hFFFF_FFFF);
    random_window(2, 1'b1);
    random_window(1, 1'b1);
    set_inv_size(32'd1);
    random_window(3, 1'b1);

    // Random windows over several register settings, short ones mostly.
    n = 0;
    for (int ph = 0; ph < 5; ph++) begin
      int len;
      case (ph)
        0: set_inv_size(InverseSizeReset);
        1: set_inv_size(32'h8000_0000);
        2: set_inv_size(32'($urandom));
        3: set_inv_size(32'h0100_0000);
        default: set_inv_size(32'hFFFF_FFFF);
      endcase
      while (n < (ph + 1) * NumRandom / 5) begin
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 600) : $urandom_range(1, 16);
        if (ph == 3 && len < 16) len = 48;
        random_window(len, $urandom_range(0, 1));
        n += len;
      end
    end

    // Window long enough to saturate both sums.
    set_inv_size(32'd16777);
    for (int i = 0; i < 300; i++) begin
      r = mk(16'hFFFF, i == 299);
      send(r.item, 1'b0, '0);
    end

    idle_input();
    while (stats_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("window_mean_stddev_core test passed");
    end else begin
      $display("window_mean_stddev_core test failed");
    end
    $finish;
  end
endmodule
